### src/path_match_point_tracker_assert.svh
// ---------------------------------------------------------------------------
// path match point tracker assertion macros
// shared property forms for the port-level checker
// ---------------------------------------------------------------------------
`ifndef PATH_MATCH_POINT_TRACKER_ASSERT_SVH
`define PATH_MATCH_POINT_TRACKER_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define PMPT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmpt port check failed");

// next-cycle implication, quiet while reset is held
`define PMPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmpt port check failed");

`endif

### src/pmpt_pkg.sv
// ---------------------------------------------------------------------------
// pmpt_pkg
// shared widths, register codes, reset values and the path point record
// ---------------------------------------------------------------------------
package pmpt_pkg;

  localparam int unsigned DEF_MAX_POINTS = 4096;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIR_W      = 16;
  localparam int unsigned PIDX_W     = 12;
  localparam int unsigned LEN_CFG_W  = 13;
  localparam int unsigned BAND_W     = 47;
  localparam int unsigned LIM_W      = 12;
  localparam int unsigned DIST_W     = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 47;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATH_LENGTH   = 2'd0,
    CFG_DEAD_BAND     = 2'd1,
    CFG_INITIAL_LIMIT = 2'd2,
    CFG_TRACK_LIMIT   = 2'd3
  } cfg_reg_t;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [LEN_CFG_W-1:0] RST_PATH_LENGTH   = 13'd4096;
  localparam logic [BAND_W-1:0]    RST_DEAD_BAND     = 47'd16777;
  localparam logic [LIM_W-1:0]     RST_INITIAL_LIMIT = 12'd50;
  localparam logic [LIM_W-1:0]     RST_TRACK_LIMIT   = 12'd5;

  // one path table entry
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [DIR_W-1:0]   hcos;
    logic signed [DIR_W-1:0]   hsin;
  } point_t;

endpackage

### src/pmpt_store.sv
// ---------------------------------------------------------------------------
// pmpt_store
// path point table, one write port and one registered read port
// ---------------------------------------------------------------------------
module pmpt_store import pmpt_pkg::*; #(
  parameter int unsigned MAX_POINTS = DEF_MAX_POINTS,
  localparam int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  point_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output point_t        rd_data
);

  point_t mem [MAX_POINTS];
  point_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/path_match_point_tracker.sv
// ---------------------------------------------------------------------------
// path_match_point_tracker
// nearest path point search with local tracking around the last match
// ---------------------------------------------------------------------------
// load item: written into the table at the accepting edge unless past the table, busy stays low
// first query: scans forward from 0, each examined point steps through dx squared, dy squared, sum and compare
// tracking query: distance to the last match and heading projection first, then the same steps per point
// hold query: result strobe from the dead band decision, with the last match kept
// pace is set by the single shared 32x32 multiplier, at most one product per cycle
// rst_n (sync, low) clears config to defaults, last match to 0, arms first query
// ---------------------------------------------------------------------------
module path_match_point_tracker import pmpt_pkg::*; #(
  parameter int unsigned MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command side
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [PIDX_W-1:0]            in_point_index,
  input  logic signed [COORD_W-1:0]    in_coord_x,
  input  logic signed [COORD_W-1:0]    in_coord_y,
  input  logic signed [DIR_W-1:0]      in_dir_x,
  input  logic signed [DIR_W-1:0]      in_dir_y,
  // result side, one-cycle strobe
  output logic                         out_valid,
  output logic [PIDX_W-1:0]            out_match_index,
  output logic [DIST_W-1:0]            out_match_dist_sq,
  // configuration writes
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned LEN_W  = IDX_W + 1;
  localparam int unsigned CMP_W  = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
  localparam int unsigned MAG_W  = COORD_W;        // |dx| never reaches 2^32
  localparam int unsigned PROJ_W = 49;             // two 47-bit terms, signed

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQX  = 7'b0000010,   // dx squared
    ST_SQY  = 7'b0000100,   // dy squared
    ST_ADD  = 7'b0001000,   // saturating sum, candidate compare
    ST_PRX  = 7'b0010000,   // dx * heading cos
    ST_PRY  = 7'b0100000,   // dy * heading sin
    ST_DEC  = 7'b1000000    // projection vs dead band
  } state_t;

  // magnitude of one product term back to signed
  function automatic logic signed [PROJ_W-1:0] signed_term(input logic [DIST_W-1:0] mag,
                                                          input logic             neg);
    logic signed [PROJ_W-1:0] t;
    t = signed'({2'b00, mag[46:0]});
    return neg ? -t : t;
  endfunction

  // ---------------- registers ----------------
  state_t                      state_r, state_nxt;
  logic [LEN_CFG_W-1:0]        path_length_r;
  logic [BAND_W-1:0]           dead_band_r;
  logic [LIM_W-1:0]            initial_limit_r;
  logic [LIM_W-1:0]            track_limit_r;
  logic [IDX_W-1:0]            last_match_r, last_match_nxt;
  logic                        first_r, first_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic signed [COORD_W-1:0]   q_x_r, q_x_nxt;
  logic signed [COORD_W-1:0]   q_y_r, q_y_nxt;
  logic [IDX_W-1:0]            j_r, j_nxt;
  logic                        fwd_r, fwd_nxt;
  logic                        scan_r, scan_nxt;    // 1 scanning, 0 projecting
  logic [LIM_W:0]              cnt_r, cnt_nxt;
  logic                        have_r, have_nxt;
  logic [DIST_W-1:0]           best_r, best_nxt;
  logic [IDX_W-1:0]            best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0]           acc_r, acc_nxt;
  logic [DIST_W-1:0]           prod_r, prod_nxt;
  logic                        neg_r, neg_nxt;
  logic signed [PROJ_W-1:0]    pacc_r, pacc_nxt;
  logic [DIST_W-1:0]           dist_p_r, dist_p_nxt;
  logic [IDX_W-1:0]            out_idx_r, out_idx_nxt;
  logic [DIST_W-1:0]           out_dist_r, out_dist_nxt;

  // ---------------- table ----------------
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  point_t                      wr_data;
  logic                        rd_en;
  point_t                      pt;

  logic [CMP_W-1:0]            idx_ext;
  logic                        idx_ok;

  assign idx_ext = CMP_W'(in_point_index);
  assign idx_ok  = idx_ext < CMP_W'(MAX_POINTS);   // loads past the table are dropped
  assign wr_addr = idx_ext[IDX_W-1:0];
  assign wr_data = '{x: in_coord_x, y: in_coord_y, hcos: in_dir_x, hsin: in_dir_y};

  pmpt_store #(
    .MAX_POINTS (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (j_nxt),
    .rd_data (pt)
  );

  // ---------------- effective path length ----------------
  // zero behaves as one, anything past the table is clipped to it
  logic [CMP_W-1:0] pl_ext;
  logic [CMP_W-1:0] len_c;
  logic [LEN_W-1:0] len;

  assign pl_ext = CMP_W'(path_length_r);
  assign len_c  = (pl_ext == '0) ? CMP_W'(1) :
                  (pl_ext > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS) : pl_ext;
  assign len    = len_c[LEN_W-1:0];

  // ---------------- offsets from the point under read ----------------
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        dx_abs, dy_abs;
  logic [MAG_W-1:0]        ax, ay;
  logic [DIR_W-1:0]        acos, asin;

  assign dx     = {q_x_r[COORD_W-1], q_x_r} - {pt.x[COORD_W-1], pt.x};
  assign dy     = {q_y_r[COORD_W-1], q_y_r} - {pt.y[COORD_W-1], pt.y};
  assign dx_abs = dx[COORD_W] ? (~dx + 1'b1) : dx;
  assign dy_abs = dy[COORD_W] ? (~dy + 1'b1) : dy;
  assign ax     = dx_abs[MAG_W-1:0];
  assign ay     = dy_abs[MAG_W-1:0];
  assign acos   = pt.hcos[DIR_W-1] ? (~pt.hcos + 1'b1) : pt.hcos;
  assign asin   = pt.hsin[DIR_W-1] ? (~pt.hsin + 1'b1) : pt.hsin;

  // ---------------- shared multiplier ----------------
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [DIST_W-1:0] mul_p;

  assign mul_p = mul_a * mul_b;

  // ---------------- sum, compare, projection ----------------
  logic [DIST_W:0]          sum_w;
  logic [DIST_W-1:0]        d;
  logic                     improve;
  logic [LIM_W:0]           cnt_inc;
  logic                     at_end;
  logic [LIM_W-1:0]         limit;
  logic signed [PROJ_W-1:0] proj;
  logic signed [PROJ_W-1:0] band_s;
  logic                     p_in_path;

  assign sum_w     = {1'b0, acc_r} + {1'b0, prod_r};
  assign d         = sum_w[DIST_W] ? '1 : sum_w[DIST_W-1:0];   // saturate
  assign improve   = !have_r || (d < best_r);  // first examined point always taken
  assign cnt_inc   = improve ? '0 : cnt_r + 1'b1;
  assign at_end    = fwd_r ? ((LEN_W'(j_r) + LEN_W'(1)) >= len) : (j_r == '0);
  assign limit     = first_r ? initial_limit_r : track_limit_r;
  assign proj      = pacc_r + signed_term(prod_r, neg_r);
  assign band_s    = signed'({2'b00, dead_band_r});
  assign p_in_path = LEN_W'(last_match_r) < len;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    last_match_nxt = last_match_r;
    first_nxt      = first_r;
    out_valid_nxt  = 1'b0;
    q_x_nxt        = q_x_r;
    q_y_nxt        = q_y_r;
    j_nxt          = j_r;
    fwd_nxt        = fwd_r;
    scan_nxt       = scan_r;
    cnt_nxt        = cnt_r;
    have_nxt       = have_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    acc_nxt        = acc_r;
    prod_nxt       = prod_r;
    neg_nxt        = neg_r;
    pacc_nxt       = pacc_r;
    dist_p_nxt     = dist_p_r;
    out_idx_nxt    = out_idx_r;
    out_dist_nxt   = out_dist_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    mul_a          = '0;
    mul_b          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_mode == MODE_QUERY) begin
            // first query scans forward from 0, later ones read the last match
            q_x_nxt      = in_coord_x;
            q_y_nxt      = in_coord_y;
            scan_nxt     = first_r;
            fwd_nxt      = 1'b1;
            j_nxt        = first_r ? '0 : last_match_r;
            best_idx_nxt = first_r ? '0 : last_match_r;
            have_nxt     = 1'b0;
            cnt_nxt      = '0;
            rd_en        = 1'b1;
            state_nxt    = ST_SQX;
          end else if (idx_ok) begin
            wr_en = 1'b1;
          end
        end
      end

      ST_SQX: begin
        mul_a     = ax;
        mul_b     = ax;
        prod_nxt  = mul_p;
        state_nxt = ST_SQY;
      end

      ST_SQY: begin
        acc_nxt   = prod_r;
        mul_a     = ay;
        mul_b     = ay;
        prod_nxt  = mul_p;
        state_nxt = ST_ADD;
      end

      ST_ADD: begin
        if (scan_r) begin
          if (improve) begin
            best_nxt     = d;
            best_idx_nxt = j_r;
            have_nxt     = 1'b1;
          end
          cnt_nxt = cnt_inc;
          if ((cnt_inc > {1'b0, limit}) || at_end) begin
            // run of non-improving points too long, or path edge reached
            out_valid_nxt  = 1'b1;
            out_idx_nxt    = improve ? j_r : best_idx_r;
            out_dist_nxt   = improve ? d : best_r;
            last_match_nxt = improve ? j_r : best_idx_r;
            first_nxt      = 1'b0;
            state_nxt      = ST_IDLE;
          end else begin
            // next point is read while this one retires
            j_nxt     = fwd_r ? (j_r + 1'b1) : (j_r - 1'b1);
            rd_en     = 1'b1;
            state_nxt = ST_SQX;
          end
        end else begin
          // distance to the last match, used on hold or when nothing is scanned
          dist_p_nxt = d;
          state_nxt  = ST_PRX;
        end
      end

      ST_PRX: begin
        mul_a     = ax;
        mul_b     = MAG_W'(acos);
        prod_nxt  = mul_p;
        neg_nxt   = dx[COORD_W] ^ pt.hcos[DIR_W-1];
        state_nxt = ST_PRY;
      end

      ST_PRY: begin
        pacc_nxt  = signed_term(prod_r, neg_r);
        mul_a     = ay;
        mul_b     = MAG_W'(asin);
        prod_nxt  = mul_p;
        neg_nxt   = dy[COORD_W] ^ pt.hsin[DIR_W-1];
        state_nxt = ST_DEC;
      end

      ST_DEC: begin
        if ((proj > band_s) && p_in_path) begin
          // ahead of the last match: walk forward, entry already in the read register
          scan_nxt  = 1'b1;
          fwd_nxt   = 1'b1;
          state_nxt = ST_SQX;
        end else if ((proj < -band_s) && p_in_path) begin
          scan_nxt  = 1'b1;
          fwd_nxt   = 1'b0;
          state_nxt = ST_SQX;
        end else begin
          // inside the dead band, or start past the path: keep the last match
          out_valid_nxt = 1'b1;
          out_idx_nxt   = last_match_r;
          out_dist_nxt  = dist_p_r;
          first_nxt     = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      last_match_r    <= '0;
      first_r         <= 1'b1;
      out_valid_r     <= 1'b0;
      path_length_r   <= RST_PATH_LENGTH;
      dead_band_r     <= RST_DEAD_BAND;
      initial_limit_r <= RST_INITIAL_LIMIT;
      track_limit_r   <= RST_TRACK_LIMIT;
    end else begin
      state_r      <= state_nxt;
      last_match_r <= last_match_nxt;
      first_r      <= first_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_PATH_LENGTH:   path_length_r   <= cfg_wdata[LEN_CFG_W-1:0];
          CFG_DEAD_BAND:     dead_band_r     <= cfg_wdata[BAND_W-1:0];
          CFG_INITIAL_LIMIT: initial_limit_r <= cfg_wdata[LIM_W-1:0];
          CFG_TRACK_LIMIT:   track_limit_r   <= cfg_wdata[LIM_W-1:0];
          default:           path_length_r   <= path_length_r;
        endcase
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    q_x_r      <= q_x_nxt;
    q_y_r      <= q_y_nxt;
    j_r        <= j_nxt;
    fwd_r      <= fwd_nxt;
    scan_r     <= scan_nxt;
    cnt_r      <= cnt_nxt;
    have_r     <= have_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    pacc_r     <= pacc_nxt;
    dist_p_r   <= dist_p_nxt;
    out_idx_r  <= out_idx_nxt;
    out_dist_r <= out_dist_nxt;
  end

  // ---------------- outputs ----------------
  logic [CMP_W-1:0] out_idx_ext;

  assign out_idx_ext       = CMP_W'(out_idx_r);
  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_match_index   = out_idx_ext[PIDX_W-1:0];
  assign out_match_dist_sq = out_dist_r;

endmodule

### src/pmpt_checker.sv
// ---------------------------------------------------------------------------
// pmpt_checker
// port-level checks on command and result timing of the tracker
// ---------------------------------------------------------------------------
`include "path_match_point_tracker_assert.svh"

module pmpt_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_mode,
  input logic out_valid
);

  // a load transfer never produces a result
  `PMPT_ASSERT_NEXT(a_load_no_result, start && !busy && !in_mode, !out_valid)
  // a query transfer always occupies the block
  `PMPT_ASSERT_NEXT(a_query_goes_busy, start && !busy && in_mode, busy)
  // results appear only once the block is free again
  `PMPT_ASSERT_SAME(a_result_when_idle, out_valid, !busy)
  // every finished query ends with exactly its result strobe
  `PMPT_ASSERT_SAME(a_result_ends_work, $fell(busy), out_valid)

endmodule

bind path_match_point_tracker pmpt_checker u_pmpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_mode   (in_mode),
  .out_valid (out_valid)
);
